>>> rtl/rgblab_pkg.sv
`default_nettype none

package rgblab_pkg;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] lightness_code;
        logic [7:0] a_code;
        logic [7:0] b_code;
    } t_lab_out;

    localparam logic [15:0] CXR = 16'd27031;
    localparam logic [15:0] CXG = 16'd23434;
    localparam logic [15:0] CXB = 16'd11825;
    localparam logic [15:0] CYR = 16'd13938;
    localparam logic [15:0] CYG = 16'd46868;
    localparam logic [15:0] CYB = 16'd4730;
    localparam logic [15:0] CZR = 16'd1267;
    localparam logic [15:0] CZG = 16'd7811;
    localparam logic [15:0] CZB = 16'd62279;
    localparam logic [16:0] WHITE_X = 17'd68951;
    localparam logic [16:0] WHITE_Z = 17'd60189;

    localparam int ROOT_STEPS = 19;
    localparam logic [17:0] F_KNEE = 18'd581;
    localparam logic [63:0] LIN_DIV_M64 = ((64'd1 << 48) + 64'd115999) / 64'd116000;
    localparam logic [31:0] LIN_DIV_M = LIN_DIV_M64[31:0];
    localparam logic [63:0] L_DIV_M64 = ((64'd1 << 54) + 64'd6553599) / 64'd6553600;
    localparam logic [31:0] L_DIV_M = L_DIV_M64[31:0];

    typedef logic [15:0] t_lin_tab [0:255];

    function automatic logic [15:0] lin_entry(input int unsigned c);
        logic [63:0] s30;
        logic [63:0] s2;
        logic [63:0] r;
        logic [63:0] cand;
        logic [63:0] p2;
        logic [63:0] p4;
        logic [63:0] p5;
        logic [63:0] lin;
        logic [63:0] res;
        if (c <= 10) begin
            res = (64'(c) * 64'd6553600) / 64'd329460;
            return res[15:0];
        end
        s30 = ((64'd1000 * 64'(c) + 64'd14025) << 30) / 64'd269025;
        s2 = (s30 * s30) >> 30;
        r = 64'd0;
        for (int bit_i = 30; bit_i >= 0; bit_i--) begin
            cand = r | (64'd1 << bit_i);
            p2 = (cand * cand) >> 30;
            p4 = (p2 * p2) >> 30;
            p5 = (p4 * cand) >> 30;
            if (cand <= (64'd1 << 30) && p5 <= s2) begin
                r = cand;
            end
        end
        lin = (s2 * r) >> 30;
        res = (lin + 64'd8192) >> 14;
        return (res > 64'd65535) ? 16'hFFFF : res[15:0];
    endfunction

    function automatic t_lin_tab build_lin_tab();
        t_lin_tab tab;
        for (int c = 0; c < 256; c++) begin
            tab[c] = lin_entry(c);
        end
        return tab;
    endfunction

    localparam t_lin_tab LIN_TAB = build_lin_tab();

    function automatic logic [7:0] code_sat(input logic signed [27:0] n);
        if (n < 0) begin
            return 8'd0;
        end
        return (n[27:16] > 12'd255) ? 8'd255 : n[23:16];
    endfunction

endpackage

`default_nettype wire

>>> rtl/rgblab_xyz.sv
`default_nettype none

module rgblab_xyz
    import rgblab_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_ce,
    input  wire logic        i_valid,
    input  wire t_pix_in     i_pix,
    output logic             o_valid,
    output logic [17:0]      o_tx,
    output logic [17:0]      o_ty,
    output logic [17:0]      o_tz
);

    logic [2:0]  r_vld;
    logic [15:0] r_lr;
    logic [15:0] r_lg;
    logic [15:0] r_lb;
    logic [16:0] r_x;
    logic [16:0] r_y;
    logic [16:0] r_z;
    logic [17:0] r_tx;
    logic [17:0] r_ty;
    logic [17:0] r_tz;
    logic [33:0] n_xs;
    logic [33:0] n_ys;
    logic [33:0] n_zs;
    logic [33:0] n_xw;
    logic [33:0] n_zw;

    always_comb begin
        n_xs = 34'(r_lr) * 34'(CXR) + 34'(r_lg) * 34'(CXG) + 34'(r_lb) * 34'(CXB) + 34'd32768;
        n_ys = 34'(r_lr) * 34'(CYR) + 34'(r_lg) * 34'(CYG) + 34'(r_lb) * 34'(CYB) + 34'd32768;
        n_zs = 34'(r_lr) * 34'(CZR) + 34'(r_lg) * 34'(CZG) + 34'(r_lb) * 34'(CZB) + 34'd32768;
        n_xw = 34'(r_x) * 34'(WHITE_X) + 34'd32768;
        n_zw = 34'(r_z) * 34'(WHITE_Z) + 34'd32768;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ce) begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_lr <= LIN_TAB[i_pix.red];
            r_lg <= LIN_TAB[i_pix.green];
            r_lb <= LIN_TAB[i_pix.blue];
            r_x  <= n_xs[32:16];
            r_y  <= n_ys[32:16];
            r_z  <= n_zs[32:16];
            r_tx <= n_xw[33:16];
            r_ty <= 18'(r_y);
            r_tz <= n_zw[33:16];
        end
    end

    assign o_valid = r_vld[2];
    assign o_tx    = r_tx;
    assign o_ty    = r_ty;
    assign o_tz    = r_tz;

endmodule

`default_nettype wire

>>> rtl/rgblab_froot.sv
`default_nettype none

module rgblab_froot
    import rgblab_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_ce,
    input  wire logic        i_valid,
    input  wire logic [17:0] i_t,
    output logic             o_valid,
    output logic [16:0]      o_f
);

    logic [18:0] r_root [0:ROOT_STEPS-1];
    logic [37:0] r_sq   [0:ROOT_STEPS-1];
    logic [49:0] r_rem  [0:ROOT_STEPS-1];
    logic        r_small[0:ROOT_STEPS-1];
    logic        r_vld  [0:ROOT_STEPS-1];
    logic [16:0] r_lin  [2:ROOT_STEPS-1];
    logic [30:0] r_m1;
    logic [62:0] r_lp;

    logic [18:0] s_root [0:ROOT_STEPS-1];
    logic [37:0] s_sq   [0:ROOT_STEPS-1];
    logic [49:0] s_rem  [0:ROOT_STEPS-1];
    logic [18:0] n_root [0:ROOT_STEPS-1];
    logic [37:0] n_sq   [0:ROOT_STEPS-1];
    logic [49:0] n_rem  [0:ROOT_STEPS-1];
    logic [59:0] c_delta[0:ROOT_STEPS-1];

    // Each stage decides one bit of the cube root, keeping root, root squared and remainder.
    always_comb begin
        s_root[0] = '0;
        s_sq[0]   = '0;
        s_rem[0]  = {i_t, 32'd0};
        for (int k = 1; k < ROOT_STEPS; k++) begin
            s_root[k] = r_root[k-1];
            s_sq[k]   = r_sq[k-1];
            s_rem[k]  = r_rem[k-1];
        end
        for (int k = 0; k < ROOT_STEPS; k++) begin
            c_delta[k] = ((60'(s_sq[k]) * 60'd3) << (ROOT_STEPS - 1 - k))
                       + ((60'(s_root[k]) * 60'd3) << (2 * (ROOT_STEPS - 1 - k)))
                       + (60'd1 << (3 * (ROOT_STEPS - 1 - k)));
            if (c_delta[k] <= 60'(s_rem[k])) begin
                n_rem[k]  = 50'(60'(s_rem[k]) - c_delta[k]);
                n_sq[k]   = 38'(60'(s_sq[k]) + (60'(s_root[k]) << (ROOT_STEPS - k))
                          + (60'd1 << (2 * (ROOT_STEPS - 1 - k))));
                n_root[k] = s_root[k] | (19'd1 << (ROOT_STEPS - 1 - k));
            end else begin
                n_rem[k]  = s_rem[k];
                n_sq[k]   = s_sq[k];
                n_root[k] = s_root[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ROOT_STEPS; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_ce) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < ROOT_STEPS; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int k = 0; k < ROOT_STEPS; k++) begin
                r_root[k] <= n_root[k];
                r_sq[k]   <= n_sq[k];
                r_rem[k]  <= n_rem[k];
            end
            r_small[0] <= (i_t < F_KNEE);
            for (int k = 1; k < ROOT_STEPS; k++) begin
                r_small[k] <= r_small[k-1];
            end
            r_m1     <= 31'(i_t[9:0]) * 31'd903292 + 31'd1048576000;
            r_lp     <= 63'(r_m1) * 63'(LIN_DIV_M);
            r_lin[2] <= 17'(r_lp[62:48]);
            for (int k = 3; k < ROOT_STEPS; k++) begin
                r_lin[k] <= r_lin[k-1];
            end
        end
    end

    assign o_valid = r_vld[ROOT_STEPS-1];
    assign o_f     = r_small[ROOT_STEPS-1] ? r_lin[ROOT_STEPS-1] : r_root[ROOT_STEPS-1][16:0];

endmodule

`default_nettype wire

>>> rtl/rgblab_code.sv
`default_nettype none

module rgblab_code
    import rgblab_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_ce,
    input  wire logic        i_valid,
    input  wire logic [16:0] i_fx,
    input  wire logic [16:0] i_fy,
    input  wire logic [16:0] i_fz,
    output logic             o_valid,
    output t_lab_out         o_lab
);

    logic [2:0]         r_vld;
    logic               r_lneg0;
    logic               r_lneg1;
    logic [30:0]        r_numl;
    logic [62:0]        r_prodl;
    logic [7:0]         r_a0;
    logic [7:0]         r_b0;
    logic [7:0]         r_a1;
    logic [7:0]         r_b1;
    t_lab_out           r_lab;
    logic [23:0]        n_l116;
    logic [23:0]        n_lofs;
    logic signed [17:0] n_adiff;
    logic signed [17:0] n_bdiff;
    logic signed [27:0] n_anum;
    logic signed [27:0] n_bnum;
    logic [8:0]         n_lq;
    logic [7:0]         n_l;

    always_comb begin
        n_l116  = 24'(i_fy) * 24'd116;
        n_lofs  = n_l116 - 24'd1048576;
        n_adiff = $signed({1'b0, i_fx}) - $signed({1'b0, i_fy});
        n_bdiff = $signed({1'b0, i_fy}) - $signed({1'b0, i_fz});
        n_anum  = 28'(n_adiff) * 28'sd500 + 28'sd8388608;
        n_bnum  = 28'(n_bdiff) * 28'sd200 + 28'sd8388608;
        n_lq    = r_prodl[62:54];
        if (r_lneg1) begin
            n_l = 8'd0;
        end else if (n_lq > 9'd255) begin
            n_l = 8'd255;
        end else begin
            n_l = n_lq[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ce) begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_lneg0 <= (n_l116 < 24'd1048576);
            r_numl  <= 31'(n_lofs) * 31'd255;
            r_a0    <= code_sat(n_anum);
            r_b0    <= code_sat(n_bnum);
            r_lneg1 <= r_lneg0;
            r_prodl <= 63'(r_numl) * 63'(L_DIV_M);
            r_a1    <= r_a0;
            r_b1    <= r_b0;
            r_lab.lightness_code <= n_l;
            r_lab.a_code         <= r_a1;
            r_lab.b_code         <= r_b1;
        end
    end

    assign o_valid = r_vld[2];
    assign o_lab   = r_lab;

endmodule

`default_nettype wire

>>> rtl/rgb_to_cielab_pixel.sv
// Pipeline: an accepted item passes through 3 color-space stages, 19 cube-root
// stages at one root bit per stage and 3 output-code stages to its result.
// Throughput: one item per cycle; the whole pipeline advances unless a valid
// result is held by the output stall.
// Reset: synchronous, active low; it clears all valid bits, data is not reset.
`default_nettype none

module rgb_to_cielab_pixel
    import rgblab_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_stall,
    input  wire t_pix_in  i_pix,
    output logic          o_valid,
    input  wire logic     i_stall,
    output t_lab_out      o_lab
);

    logic        ce;
    logic        xyz_valid;
    logic [17:0] tx;
    logic [17:0] ty;
    logic [17:0] tz;
    logic        fx_valid;
    logic        fy_valid;
    logic        fz_valid;
    logic [16:0] fx;
    logic [16:0] fy;
    logic [16:0] fz;

    assign ce      = !o_valid || !i_stall;
    assign o_stall = !ce;

    rgblab_xyz u_xyz (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (i_valid),
        .i_pix   (i_pix),
        .o_valid (xyz_valid),
        .o_tx    (tx),
        .o_ty    (ty),
        .o_tz    (tz)
    );

    rgblab_froot u_fx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (xyz_valid),
        .i_t     (tx),
        .o_valid (fx_valid),
        .o_f     (fx)
    );

    rgblab_froot u_fy (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (xyz_valid),
        .i_t     (ty),
        .o_valid (fy_valid),
        .o_f     (fy)
    );

    rgblab_froot u_fz (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (xyz_valid),
        .i_t     (tz),
        .o_valid (fz_valid),
        .o_f     (fz)
    );

    rgblab_code u_code (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (fx_valid && fy_valid && fz_valid),
        .i_fx    (fx),
        .i_fy    (fy),
        .i_fz    (fz),
        .o_valid (o_valid),
        .o_lab   (o_lab)
    );

endmodule

`default_nettype wire

>>> rtl/rgblab_check.sv
`default_nettype none

module rgblab_check
    import rgblab_pkg::*;
(
    input wire logic     i_clk,
    input wire logic     i_rst_n,
    input wire logic     i_valid,
    input wire logic     o_stall,
    input wire t_pix_in  i_pix,
    input wire logic     o_valid,
    input wire logic     i_stall,
    input wire t_lab_out o_lab
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_lab))
        else $error("Stalled result item changed.");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_pix))
        else $error("Stalled input item changed.");

    a_stall_only_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("Input stalled while the output could move.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("Result item valid right after reset.");

endmodule

bind rgb_to_cielab_pixel rgblab_check u_rgblab_check (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_pix   (i_pix),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_lab   (o_lab)
);

`default_nettype wire

>>> test/tb.sv
`timescale 1ns / 100ps

module tb;
    import rgblab_pkg::*;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_stall_dut;
    t_pix_in  in_pix = '0;
    logic     out_valid;
    logic     out_stall = 1'b0;
    t_lab_out out_lab;

    rgb_to_cielab_pixel dut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_valid(in_valid),
        .o_stall(in_stall_dut),
        .i_pix(in_pix),
        .o_valid(out_valid),
        .i_stall(out_stall),
        .o_lab(out_lab)
    );

    always #4 clk = ~clk;

    t_pix_in  pending_pixels[$];
    t_lab_out expected_lab[$];
    int       mismatches = 0;
    int       cycle_count = 0;
    int       send_idle_pct = 33;
    int       recv_idle_pct = 51;
    bit       sending = 1'b0;
    bit       in_taken = 1'b0;

    function automatic logic [15:0] gamma_to_linear(input logic [7:0] c);
        logic [63:0] s30, s2, r, cand, p2, p4, p5, lin, res;
        if (c <= 8'd10) begin
            res = (64'(c) * 64'd6553600) / 64'd329460;
            return res[15:0];
        end
        s30 = ((64'd1000 * 64'(c) + 64'd14025) << 30) / 64'd269025;
        s2 = (s30 * s30) >> 30;
        r = '0;
        for (int k = 30; k >= 0; k--) begin
            cand = r | (64'd1 << k);
            p2 = (cand * cand) >> 30;
            p4 = (p2 * p2) >> 30;
            p5 = (p4 * cand) >> 30;
            if (cand <= (64'd1 << 30) && p5 <= s2) begin
                r = cand;
            end
        end
        lin = (s2 * r) >> 30;
        res = (lin + 64'd8192) >> 14;
        return (res > 64'd65535) ? 16'hFFFF : res[15:0];
    endfunction

    function automatic longint lab_curve(input longint t);
        longint v, r, cand;
        if (t < 581) begin
            return (t * 903292 + 1048576000) / 116000;
        end
        if (t > 'h3FFFF) begin
            t = 'h3FFFF;
        end
        v = t << 32;
        r = 0;
        for (int k = 18; k >= 0; k--) begin
            cand = r | (longint'(1) << k);
            if (cand * cand * cand <= v) begin
                r = cand;
            end
        end
        return r;
    endfunction

    function automatic logic [7:0] clamp_code(input longint num, input longint den);
        longint q;
        if (num < 0) begin
            return 8'd0;
        end
        q = num / den;
        return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    function automatic t_lab_out convert_pixel(input t_pix_in p);
        longint rl, gl, bl, x, y, z, fx, fy, fz;
        t_lab_out o;
        rl = gamma_to_linear(p.red);
        gl = gamma_to_linear(p.green);
        bl = gamma_to_linear(p.blue);
        x = (27031 * rl + 23434 * gl + 11825 * bl + 32768) >>> 16;
        y = (13938 * rl + 46868 * gl + 4730 * bl + 32768) >>> 16;
        z = (1267 * rl + 7811 * gl + 62279 * bl + 32768) >>> 16;
        x = (x * 68951 + 32768) >>> 16;
        z = (z * 60189 + 32768) >>> 16;
        fx = lab_curve(x);
        fy = lab_curve(y);
        fz = lab_curve(z);
        o.lightness_code = clamp_code((116 * fy - 16 * 65536) * 255, 100 * 65536);
        o.a_code = clamp_code(500 * (fx - fy) + 128 * 65536, 65536);
        o.b_code = clamp_code(200 * (fy - fz) + 128 * 65536, 65536);
        return o;
    endfunction

    always @(negedge clk) begin
        if (rst_n) begin
            if (!in_valid || in_taken) begin
                if (sending && pending_pixels.size() > 0
                        && $urandom_range(99) >= send_idle_pct) begin
                    in_pix <= pending_pixels.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        in_taken <= rst_n && in_valid && !in_stall_dut;
        if (rst_n) begin
            if (in_valid && !in_stall_dut) begin
                expected_lab.insert(expected_lab.size(), convert_pixel(in_pix));
            end
            if (out_valid && !out_stall) begin
                if (expected_lab.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("unexpected result %h", out_lab);
                    end
                    mismatches <= mismatches + 1;
                end else begin
                    if (out_lab !== expected_lab[0]) begin
                        if (mismatches < 10) begin
                            $display("mismatch: expected L=%0d a=%0d b=%0d got L=%0d a=%0d b=%0d",
                                expected_lab[0].lightness_code, expected_lab[0].a_code,
                                expected_lab[0].b_code, out_lab.lightness_code,
                                out_lab.a_code, out_lab.b_code);
                        end
                        mismatches <= mismatches + 1;
                    end
                    void'(expected_lab.pop_front());
                end
            end
        end
    end

    task automatic run_phase(input int send_pct, input int recv_pct, input int count);
        t_pix_in p;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int k = 0; k < count; k++) begin
            p.red = 8'($urandom);
            p.green = 8'($urandom);
            p.blue = 8'($urandom);
            case ($urandom_range(3))
                0: p = {3{8'($urandom_range(255))}};
                1: p.red = $urandom_range(1) ? 8'($urandom_range(12)) : 8'd255;
                default: ;
            endcase
            pending_pixels.insert(pending_pixels.size(), p);
        end
        while (pending_pixels.size() > 0 || in_valid) begin
            @(posedge clk);
        end
    endtask

    initial begin
        logic [7:0] corners[6];
        corners = '{8'd0, 8'd1, 8'd10, 8'd11, 8'd128, 8'd255};
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        for (int k = 0; k < 6; k++) begin
            pending_pixels.insert(pending_pixels.size(), {corners[k], corners[k], corners[k]});
        end
        pending_pixels.insert(pending_pixels.size(), {8'd255, 8'd0, 8'd0});
        pending_pixels.insert(pending_pixels.size(), {8'd0, 8'd255, 8'd0});
        pending_pixels.insert(pending_pixels.size(), {8'd0, 8'd0, 8'd255});
        pending_pixels.insert(pending_pixels.size(), {8'd255, 8'd255, 8'd0});
        pending_pixels.insert(pending_pixels.size(), {8'd0, 8'd255, 8'd255});
        pending_pixels.insert(pending_pixels.size(), {8'd255, 8'd0, 8'd255});
        pending_pixels.insert(pending_pixels.size(), {8'hAA, 8'h55, 8'hAA});
        pending_pixels.insert(pending_pixels.size(), {8'h55, 8'hAA, 8'h55});
        sending = 1'b1;
        run_phase(33, 51, 270);
        run_phase(51, 33, 270);
        run_phase(0, 0, 260);
        while (expected_lab.size() > 0) begin
            @(posedge clk);
        end
        repeat (40) @(posedge clk);
        if (mismatches == 0 && expected_lab.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    always @(posedge clk) begin
        if (cycle_count > 200000) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end
endmodule
